@@ rtl/psp_pkg.sv @@
// Shared types, constants and command structs for the pending table.
`default_nettype none
package psp_pkg;
   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int NSTAT = 6;
   localparam logic [31:0] XID_RESET = 32'd99;
   localparam logic [7:0] AGE_RESET = 8'd5;

   // word kinds
   localparam logic [1:0] KIND_PACKET = 2'd0;
   localparam logic [1:0] KIND_CLAIM = 2'd1;
   localparam logic [1:0] KIND_DISP = 2'd2;
   localparam logic [1:0] KIND_STAT = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_NONE = 3'd2;
   localparam logic [2:0] ST_OFF = 3'd3;
   localparam logic [2:0] ST_NOMATCH = 3'd4;

   // verdicts
   localparam logic [1:0] VD_NONE = 2'd0;
   localparam logic [1:0] VD_FWD = 2'd1;
   localparam logic [1:0] VD_NOTIFY = 2'd2;
   localparam logic [1:0] VD_DROP = 2'd3;

   // statistic indexes
   localparam logic [2:0] SC_PACKETS = 3'd0;
   localparam logic [2:0] SC_NOBUF = 3'd1;
   localparam logic [2:0] SC_ACCEPT = 3'd2;
   localparam logic [2:0] SC_REJECT = 3'd3;
   localparam logic [2:0] SC_BADSYNC = 3'd4;
   localparam logic [2:0] SC_STALE = 3'd5;

   // register indexes
   localparam logic [0:0] CSR_SCREEN_ON = 1'b0;
   localparam logic [0:0] CSR_MAX_AGE = 1'b1;

   // scan operations run by the datapath
   typedef enum logic [2:0] {
      OP_FREE, OP_CLAIM, OP_PURGE, OP_MATCH, OP_FLUSH
   } scan_op_type;

   typedef struct packed {
      logic load;        // capture request word
      logic scan_start;  // clear scan pointer and trackers
      logic scan_step;   // examine one slot
      scan_op_type op;
      logic do_store;    // write new entry into free slot
      logic do_own;      // set owner of best slot
      logic do_free;     // free matched slot
      logic out_load;    // compose result
   } psp_cmd_type;

   typedef struct packed {
      logic scan_last;   // current step is the final slot
      logic found;       // tracker holds a slot
   } psp_sts_type;
endpackage
`default_nettype wire

@@ rtl/psp_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module psp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic clock,
   input  wire logic we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

@@ rtl/psp_datapath.sv @@
// Slot storage, scan pointer, age trackers, counters and result registers.
`default_nettype none
module psp_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire psp_pkg::psp_cmd_type cmd,
   output psp_pkg::psp_sts_type sts,
   input  wire logic cfg_screen_on,
   input  wire logic [7:0] cfg_max_age,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_family,
   input  wire logic [15:0] req_packet_handle,
   input  wire logic [15:0] req_requester,
   input  wire logic [31:0] req_xid,
   input  wire logic req_accept_flag,
   input  wire logic req_notify_flag,
   input  wire logic [31:0] req_now_seconds,
   input  wire logic [2:0] req_stat_select,
   output logic [2:0] rsp_status,
   output logic [1:0] rsp_verdict,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_out_xid,
   output logic [7:0] rsp_out_family,
   output logic [31:0] rsp_arrival_seconds,
   output logic [4:0] rsp_flushed_count,
   output logic [31:0] rsp_stat_value
);
   localparam int IW = psp_pkg::IDX_W;
   localparam int CW = psp_pkg::CNT_W;

   // captured request word
   logic [1:0] kind_ff;
   logic [7:0] fam_ff;
   logic [15:0] hdl_ff, reqr_ff;
   logic [31:0] xid_ff, now_ff;
   logic acc_ff, ntf_ff;
   logic [2:0] sel_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         fam_ff <= req_family;
         hdl_ff <= req_packet_handle;
         reqr_ff <= req_requester;
         xid_ff <= req_xid;
         acc_ff <= req_accept_flag;
         ntf_ff <= req_notify_flag;
         now_ff <= req_now_seconds;
         sel_ff <= req_stat_select;
      end
   end

   // slot metadata held in flops (small fields scanned every cycle)
   logic [psp_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [15:0] owner_ff [psp_pkg::ENTRIES];
   logic [31:0] sxid_ff [psp_pkg::ENTRIES];
   logic [7:0] sfam_ff [psp_pkg::ENTRIES];
   logic [31:0] sarr_ff [psp_pkg::ENTRIES];
   logic [31:0] next_xid_ff;
   logic [31:0] stat_ff [psp_pkg::NSTAT];

   // scan state
   logic [CW-1:0] ptr_ff;
   logic [IW-1:0] pidx;
   logic [IW-1:0] best_ff;
   logic found_ff;
   logic [31:0] limit_ff;
   logic [CW-1:0] flushed_ff;
   assign pidx = ptr_ff[IW-1:0];

   // handle RAM: one port, addressed by the free or best slot
   logic [15:0] hdl_rd;
   psp_ram #(.WIDTH(16), .DEPTH(psp_pkg::ENTRIES)) u_hdl (
      .clock(clock), .we(cmd.do_store), .addr(best_ff),
      .wdata(hdl_ff), .rdata(hdl_rd)
   );

   // per-step tests on the slot under the pointer
   logic sv, fam_ok, own_req;
   logic [31:0] age_p, age_b;
   logic signed [33:0] cutoff;
   assign sv = valid_ff[pidx];
   assign fam_ok = (fam_ff == 8'd0) || (fam_ff == sfam_ff[pidx]);
   assign own_req = (owner_ff[pidx] == reqr_ff);
   assign age_p = next_xid_ff - sxid_ff[pidx];
   assign age_b = next_xid_ff - sxid_ff[best_ff];
   assign cutoff = $signed({2'b00, now_ff}) - $signed({26'd0, cfg_max_age}) - 34'sd1;

   logic stale, flush_hit, take;
   always_comb begin
      stale = sv && ($signed({2'b00, sarr_ff[pidx]}) < cutoff);
      flush_hit = sv && own_req && (reqr_ff != 16'd0) &&
                  !(found_ff && pidx == best_ff) &&
                  (!found_ff || age_p > limit_ff);
      take = 1'b0;
      unique case (cmd.op)
         psp_pkg::OP_FREE: take = !sv && !found_ff;
         psp_pkg::OP_CLAIM:
            take = sv && owner_ff[pidx] == 16'd0 && fam_ok && (!found_ff || age_p > age_b);
         psp_pkg::OP_MATCH:
            take = sv && own_req && reqr_ff != 16'd0 && sxid_ff[pidx] == xid_ff && !found_ff;
         psp_pkg::OP_PURGE, psp_pkg::OP_FLUSH: take = 1'b0;
         default: take = 1'b0;
      endcase
   end

   assign sts.scan_last = (ptr_ff == CW'(psp_pkg::ENTRIES - 1));
   assign sts.found = found_ff;

   logic [CW-1:0] fl_inc;
   assign fl_inc = (cmd.scan_step && ((cmd.op == psp_pkg::OP_PURGE && stale) ||
                    (cmd.op == psp_pkg::OP_FLUSH && flush_hit))) ? CW'(1) : CW'(0);

   // valid bit updates
   always_comb begin
      valid_in = valid_ff;
      if (cmd.scan_step && fl_inc != CW'(0)) valid_in[pidx] = 1'b0;
      if (cmd.do_store) valid_in[best_ff] = 1'b1;
      if (cmd.do_free) valid_in[best_ff] = 1'b0;
   end

   // scan pointer and trackers; the pointer wraps to slot 0 after the last slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff <= '0;
         found_ff <= 1'b0;
         next_xid_ff <= psp_pkg::XID_RESET;
         for (int s = 0; s < psp_pkg::NSTAT; s++) stat_ff[s] <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.scan_start) begin
            ptr_ff <= '0;
            found_ff <= 1'b0;
            flushed_ff <= '0;
         end else if (cmd.scan_step) begin
            ptr_ff <= (ptr_ff == CW'(psp_pkg::ENTRIES - 1)) ? '0 : ptr_ff + CW'(1);
            flushed_ff <= flushed_ff + fl_inc;
            if (take) begin
               found_ff <= 1'b1;
               best_ff <= pidx;
               limit_ff <= age_p;
            end
         end
         if (cmd.do_store) begin
            sxid_ff[best_ff] <= next_xid_ff;
            sfam_ff[best_ff] <= fam_ff;
            sarr_ff[best_ff] <= now_ff;
            owner_ff[best_ff] <= 16'd0;
            next_xid_ff <= next_xid_ff + 32'd1;
         end
         if (cmd.do_own) owner_ff[best_ff] <= reqr_ff;
         // statistic counters
         if (cmd.scan_step && cmd.op == psp_pkg::OP_PURGE && stale)
            stat_ff[psp_pkg::SC_STALE] <= stat_ff[psp_pkg::SC_STALE] + 32'd1;
         if (cmd.scan_step && cmd.op == psp_pkg::OP_FLUSH && flush_hit)
            stat_ff[psp_pkg::SC_BADSYNC] <= stat_ff[psp_pkg::SC_BADSYNC] + 32'd1;
         if (cmd.out_load && kind_ff == psp_pkg::KIND_PACKET && cfg_screen_on) begin
            stat_ff[psp_pkg::SC_PACKETS] <= stat_ff[psp_pkg::SC_PACKETS] + 32'd1;
            if (!found_ff)
               stat_ff[psp_pkg::SC_NOBUF] <= stat_ff[psp_pkg::SC_NOBUF] + 32'd1;
         end
         if (cmd.do_free) begin
            if (acc_ff) stat_ff[psp_pkg::SC_ACCEPT] <= stat_ff[psp_pkg::SC_ACCEPT] + 32'd1;
            else stat_ff[psp_pkg::SC_REJECT] <= stat_ff[psp_pkg::SC_REJECT] + 32'd1;
         end
      end
   end

   // result composition
   logic [4:0] fl_sat;
   assign fl_sat = (32'(flushed_ff) > 32'd31) ? 5'd31 : 5'(flushed_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status <= psp_pkg::ST_OK;
         rsp_verdict <= psp_pkg::VD_NONE;
         rsp_out_handle <= '0;
         rsp_out_xid <= '0;
         rsp_out_family <= '0;
         rsp_arrival_seconds <= '0;
         rsp_flushed_count <= '0;
         rsp_stat_value <= '0;
         unique case (kind_ff)
            psp_pkg::KIND_PACKET: begin
               rsp_out_handle <= hdl_ff;
               if (!cfg_screen_on) begin
                  rsp_verdict <= psp_pkg::VD_FWD;
               end else if (!found_ff) begin
                  rsp_status <= psp_pkg::ST_FULL;
                  rsp_verdict <= psp_pkg::VD_DROP;
               end else begin
                  rsp_out_xid <= next_xid_ff - 32'd1;
               end
            end
            psp_pkg::KIND_STAT: begin
               if (sel_ff < 3'(psp_pkg::NSTAT)) rsp_stat_value <= stat_ff[sel_ff];
            end
            psp_pkg::KIND_CLAIM: begin
               if (!cfg_screen_on) begin
                  rsp_status <= psp_pkg::ST_OFF;
               end else if (found_ff) begin
                  rsp_out_handle <= hdl_rd;
                  rsp_out_xid <= sxid_ff[best_ff];
                  rsp_out_family <= sfam_ff[best_ff];
                  rsp_arrival_seconds <= sarr_ff[best_ff];
               end else begin
                  rsp_status <= psp_pkg::ST_NONE;
                  rsp_flushed_count <= fl_sat;
               end
            end
            psp_pkg::KIND_DISP: begin
               if (!cfg_screen_on) begin
                  rsp_status <= psp_pkg::ST_OFF;
               end else begin
                  rsp_flushed_count <= fl_sat;
                  if (!found_ff) begin
                     rsp_status <= psp_pkg::ST_NOMATCH;
                  end else begin
                     rsp_out_handle <= hdl_rd;
                     rsp_out_xid <= sxid_ff[best_ff];
                     rsp_verdict <= acc_ff ? psp_pkg::VD_FWD :
                                    (ntf_ff ? psp_pkg::VD_NOTIFY : psp_pkg::VD_DROP);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // a stored slot must have been free
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_store |-> !valid_ff[best_ff]) else $error("store over live slot");
   // the slot being freed by a disposition is live
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_free |-> valid_ff[best_ff]) else $error("free of dead slot");
   // a store advances the transaction id by one
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_store |=> next_xid_ff == $past(next_xid_ff) + 32'd1)
      else $error("xid not advanced");
endmodule
`default_nettype wire

@@ rtl/psp_ctrl.sv @@
// Sequencer: handshakes and the order of table scans for each word.
`default_nettype none
module psp_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic [1:0] req_kind,
   input  wire logic cfg_screen_on,
   input  wire psp_pkg::psp_sts_type sts,
   output psp_pkg::psp_cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FREE, S_CLAIM, S_PURGE, S_MATCH, S_FLUSH,
      S_READ, S_WAIT, S_OUT, S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] kind_ff;
   logic rsp_valid_in, rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      cmd.op = psp_pkg::OP_FREE;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            cmd.scan_start = 1'b1;
            if (kind_ff == psp_pkg::KIND_STAT || !cfg_screen_on) state_in = S_OUT;
            else if (kind_ff == psp_pkg::KIND_PACKET) state_in = S_FREE;
            else if (kind_ff == psp_pkg::KIND_CLAIM) state_in = S_CLAIM;
            else state_in = S_MATCH;
         end
         S_FREE: begin
            cmd.op = psp_pkg::OP_FREE;
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_READ;
         end
         S_CLAIM: begin
            cmd.op = psp_pkg::OP_CLAIM;
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_READ;
         end
         S_PURGE: begin
            cmd.op = psp_pkg::OP_PURGE;
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_OUT;
         end
         S_MATCH: begin
            cmd.op = psp_pkg::OP_MATCH;
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            // restart pointer, keep match tracker
            cmd.op = psp_pkg::OP_FLUSH;
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_READ;
         end
         S_READ: begin
            if (kind_ff == psp_pkg::KIND_PACKET) begin
               cmd.do_store = sts.found;
               state_in = S_OUT;
            end else if (kind_ff == psp_pkg::KIND_CLAIM && !sts.found) begin
               cmd.scan_start = 1'b1;
               state_in = S_PURGE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_OUT;
         end
         S_OUT: if (!rsp_valid_ff) begin
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            cmd.do_own = (kind_ff == psp_pkg::KIND_CLAIM) && cfg_screen_on && sts.found;
            cmd.do_free = (kind_ff == psp_pkg::KIND_DISP) && cfg_screen_on && sts.found;
            state_in = S_HOLD;
         end
         S_HOLD: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff <= psp_pkg::KIND_PACKET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) kind_ff <= req_kind;
      end
   end

   // one word in flight: no accept while a scan runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready during scan");
   // a result appears only after the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT) else $error("stray result");
   // the free-slot scan always ends in the read step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE && sts.scan_last) |=> state_ff == S_READ)
      else $error("scan did not end");
endmodule
`default_nettype wire

@@ rtl/packet_screen_pending_table.sv @@
// Top level of the packet screening pending table.
// Usage:
//   Request words enter on req_* (valid/ready). kind selects packet arrival,
//   claim, disposition or statistic read. Each word yields one result word on
//   rsp_* (valid/ready). Configuration (screen_on, max_age) is written on the
//   csr_* channel, index 0 or 1, always ready; write it only while idle.
//   One word at a time. A packet is dispatched, runs the free-slot scan,
//   is stored when a free slot is found and goes to output; a claim runs
//   the claim scan and falls back to a stale purge scan when it finds no
//   slot; a disposition runs the match scan then the bad-sync flush scan;
//   statistic reads and words with screening off go from dispatch straight
//   to output. The next word can be taken while the result still waits to
//   be accepted. The slot scan examines one slot per cycle over ENTRIES slots.
//   Reset clears all slot valid bits, the statistic counters, sets the next
//   transaction id to 99, screen_on to 0 and max_age to 5. No clearing pass.
//   When the receiver stalls the result is held and the next word's result
//   waits until the held one has been accepted.
//   Transaction ids and counters wrap; flushed_count saturates at 31.
`default_nettype none
module packet_screen_pending_table (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_family,
   input  wire logic [15:0] req_packet_handle,
   input  wire logic [15:0] req_requester,
   input  wire logic [31:0] req_xid,
   input  wire logic req_accept_flag,
   input  wire logic req_notify_flag,
   input  wire logic [31:0] req_now_seconds,
   input  wire logic [2:0] req_stat_select,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [1:0] rsp_verdict,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_out_xid,
   output logic [7:0] rsp_out_family,
   output logic [31:0] rsp_arrival_seconds,
   output logic [4:0] rsp_flushed_count,
   output logic [31:0] rsp_stat_value,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [0:0] csr_index,
   input  wire logic [7:0] csr_data
);
   psp_pkg::psp_cmd_type cmd;
   psp_pkg::psp_sts_type sts;
   logic screen_on_ff;
   logic [7:0] max_age_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_on_ff <= 1'b0;
         max_age_ff <= psp_pkg::AGE_RESET;
      end else if (csr_valid) begin
         if (csr_index == psp_pkg::CSR_SCREEN_ON) screen_on_ff <= csr_data[0];
         else max_age_ff <= csr_data;
      end
   end

   psp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .req_kind(req_kind), .cfg_screen_on(screen_on_ff),
      .sts(sts), .cmd(cmd)
   );

   psp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .cfg_screen_on(screen_on_ff), .cfg_max_age(max_age_ff),
      .req_kind(req_kind), .req_family(req_family),
      .req_packet_handle(req_packet_handle), .req_requester(req_requester),
      .req_xid(req_xid), .req_accept_flag(req_accept_flag),
      .req_notify_flag(req_notify_flag), .req_now_seconds(req_now_seconds),
      .req_stat_select(req_stat_select),
      .rsp_status(rsp_status), .rsp_verdict(rsp_verdict),
      .rsp_out_handle(rsp_out_handle), .rsp_out_xid(rsp_out_xid),
      .rsp_out_family(rsp_out_family), .rsp_arrival_seconds(rsp_arrival_seconds),
      .rsp_flushed_count(rsp_flushed_count), .rsp_stat_value(rsp_stat_value)
   );
endmodule
`default_nettype wire
